FILE: rtl/core/chunk_size_line_parser_assert.svh
// ----------------------------------------------------------------------------
// chunk size line parser assertion macros
// concurrent checks, compiled out when SYNTH is defined
// ----------------------------------------------------------------------------
`ifndef CHUNK_SIZE_LINE_PARSER_ASSERT_SVH
`define CHUNK_SIZE_LINE_PARSER_ASSERT_SVH

`ifndef SYNTH
// same-cycle implication
`define CSP_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// next-cycle implication
`define CSP_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define CSP_ASSERT_IMP(lbl, ante, cons, msg)
`define CSP_ASSERT_NXT(lbl, ante, cons, msg)
`endif

`endif

FILE: rtl/core/csp_pkg.sv
// ----------------------------------------------------------------------------
// csp_pkg
// shared types, character codes and helpers of the chunk size line parser
// ----------------------------------------------------------------------------
package csp_pkg;

  // default width of the size accumulator
  localparam int SIZE_BITS_DEF = 64;
  // width of the chunk size result port
  localparam int OUT_BITS = 64;

  // character codes
  localparam logic [7:0] CHR_SEMI  = 8'h3B;
  localparam logic [7:0] CHR_CR    = 8'h0D;
  localparam logic [7:0] CHR_LF    = 8'h0A;
  localparam logic [7:0] CHR_TAB   = 8'h09;
  localparam logic [7:0] CHR_SPACE = 8'h20;

  // parse phase of the line
  typedef enum logic [1:0] {
    PH_DIGITS = 2'd0,
    PH_TRAIL  = 2'd1,
    PH_EXT    = 2'd2
  } phase_t;

  // result status codes
  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_LINEBREAK = 3'd1,
    ST_EMPTY     = 3'd2,
    ST_INVALID   = 3'd3,
    ST_OVERFLOW  = 3'd4
  } status_t;

  // one input item
  typedef struct packed {
    logic [7:0] char_byte;
    logic       has_byte;
    logic       end_of_line;
  } item_t;

  // one result item
  typedef struct packed {
    logic [OUT_BITS-1:0] chunk_size;
    status_t             status;
  } result_t;

  // hex digit decode: bit 4 set when the byte is a digit, low nibble its value
  function automatic logic [4:0] hex_decode(input logic [7:0] c);
    logic [4:0] r;
    r = 5'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r = {1'b1, c[3:0]};
    end else if ((c >= 8'h61 && c <= 8'h66) || (c >= 8'h41 && c <= 8'h46)) begin
      r = {1'b1, c[3:0] + 4'd9};
    end
    return r;
  endfunction

  // space or tab
  function automatic logic is_blank(input logic [7:0] c);
    return (c == CHR_SPACE) || (c == CHR_TAB);
  endfunction

endpackage

FILE: rtl/core/csp_in_stage.sv
// ----------------------------------------------------------------------------
// csp_in_stage
// input register of the parser, refilled in the cycle it is drained
// ----------------------------------------------------------------------------
module csp_in_stage (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_valid,
  output logic           in_ready,
  input  csp_pkg::item_t in_item,
  output logic           s_valid,
  output csp_pkg::item_t s_item,
  input  logic           s_adv
);

  logic           s_valid_r;
  csp_pkg::item_t s_item_r;

  // free when empty or emptied this cycle
  assign in_ready = !s_valid_r || s_adv;
  assign s_valid  = s_valid_r;
  assign s_item   = s_item_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s_valid_r <= 1'b0;
    end else if (in_valid && in_ready) begin
      s_valid_r <= 1'b1;
    end else if (s_adv) begin
      s_valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s_item_r <= in_item;
    end
  end

endmodule

FILE: rtl/core/csp_parser.sv
// ----------------------------------------------------------------------------
// csp_parser
// line state and the per-byte update, builds the result at end of line
// ----------------------------------------------------------------------------
module csp_parser #(
  parameter int SIZE_BITS = csp_pkg::SIZE_BITS_DEF
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             s_valid,
  input  csp_pkg::item_t   s_item,
  output logic             s_adv,
  input  logic             res_ready,
  output logic             res_push,
  output csp_pkg::result_t res
);

  csp_pkg::phase_t        phase_r,  phase_nxt;
  logic [SIZE_BITS-1:0]   accum_r,  accum_nxt;
  csp_pkg::status_t       err_r,    err_nxt;
  logic                   lb_r,     lb_nxt;
  logic                   ne_r,     ne_nxt;
  logic [4:0]             hex;
  logic                   blank;
  logic                   ovf;
  csp_pkg::status_t       st;

  assign hex   = csp_pkg::hex_decode(s_item.char_byte);
  assign blank = csp_pkg::is_blank(s_item.char_byte);
  assign ovf   = |accum_r[SIZE_BITS-1 -: 4];

  // an end-of-line item waits for room in the result register
  assign s_adv    = s_valid && (!s_item.end_of_line || res_ready);
  assign res_push = s_adv && s_item.end_of_line;

  // per-byte state update
  always_comb begin
    phase_nxt = phase_r;
    accum_nxt = accum_r;
    err_nxt   = err_r;
    lb_nxt    = lb_r;
    ne_nxt    = ne_r;
    if (s_item.has_byte) begin
      if (s_item.char_byte == csp_pkg::CHR_CR || s_item.char_byte == csp_pkg::CHR_LF) begin
        lb_nxt = 1'b1;
      end
      case (phase_r)
        csp_pkg::PH_DIGITS: begin
          ne_nxt = 1'b1;
          if (s_item.char_byte == csp_pkg::CHR_SEMI) begin
            phase_nxt = csp_pkg::PH_EXT;
            ne_nxt    = ne_r;
          end else if (blank) begin
            if (!ne_r && err_r == csp_pkg::ST_OK) begin
              err_nxt = csp_pkg::ST_INVALID;
            end
            phase_nxt = csp_pkg::PH_TRAIL;
          end else if (!hex[4]) begin
            if (err_r == csp_pkg::ST_OK) begin
              err_nxt = csp_pkg::ST_INVALID;
            end
          end else if (err_r == csp_pkg::ST_OK) begin
            if (ovf) begin
              err_nxt = csp_pkg::ST_OVERFLOW;
            end else begin
              accum_nxt = {accum_r[SIZE_BITS-5:0], hex[3:0]};
            end
          end
        end
        csp_pkg::PH_TRAIL: begin
          ne_nxt = 1'b1;
          if (s_item.char_byte == csp_pkg::CHR_SEMI) begin
            phase_nxt = csp_pkg::PH_EXT;
            ne_nxt    = ne_r;
          end else if (!blank && err_r == csp_pkg::ST_OK) begin
            err_nxt = csp_pkg::ST_INVALID;
          end
        end
        default: begin
          // chunk extension: bytes only checked for line breaks
        end
      endcase
    end
  end

  // result from the updated state
  always_comb begin
    if (lb_nxt) begin
      st = csp_pkg::ST_LINEBREAK;
    end else if (!ne_nxt) begin
      st = csp_pkg::ST_EMPTY;
    end else begin
      st = err_nxt;
    end
    res.status     = st;
    res.chunk_size = (st == csp_pkg::ST_OK) ? csp_pkg::OUT_BITS'(accum_nxt)
                                            : '0;
  end

  // line state, cleared after each line
  always_ff @(posedge clk) begin
    if (!rst_n || res_push) begin
      phase_r <= csp_pkg::PH_DIGITS;
      accum_r <= '0;
      err_r   <= csp_pkg::ST_OK;
      lb_r    <= 1'b0;
      ne_r    <= 1'b0;
    end else if (s_adv) begin
      phase_r <= phase_nxt;
      accum_r <= accum_nxt;
      err_r   <= err_nxt;
      lb_r    <= lb_nxt;
      ne_r    <= ne_nxt;
    end
  end

endmodule

FILE: rtl/core/csp_out_stage.sv
// ----------------------------------------------------------------------------
// csp_out_stage
// result register, refilled in the cycle it is taken
// ----------------------------------------------------------------------------
module csp_out_stage (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             res_push,
  input  csp_pkg::result_t res,
  output logic             res_ready,
  output logic             out_valid,
  input  logic             out_ready,
  output csp_pkg::result_t out_res
);

  logic             out_valid_r;
  csp_pkg::result_t out_res_r;

  assign res_ready = !out_valid_r || out_ready;
  assign out_valid = out_valid_r;
  assign out_res   = out_res_r;

  // occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_push) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  // payload capture
  always_ff @(posedge clk) begin
    if (res_push) begin
      out_res_r <= res;
    end
  end

endmodule

FILE: rtl/core/chunk_size_line_parser.sv
// ----------------------------------------------------------------------------
// chunk_size_line_parser
// parses one chunk-size line, a byte per transfer, into a size and a status
// ----------------------------------------------------------------------------
//  channel | direction | handshake            | payload
//  in_     | input     | in_valid / in_ready   | char_byte, has_byte, end_of_line
//  out_    | output    | out_valid / out_ready | chunk_size, status
//
//  one byte per cycle sustained; the per-byte update is a nibble shift and
//  a few compares between the input register and the line state
//  the end-of-line item waits in the input register until the result register
//  has room, and the result built from it then loads into the result register
//  reset is synchronous on rst_n and clears the line state and both stages
//  a stalled result only blocks input once an end-of-line item is waiting
// ----------------------------------------------------------------------------
`include "chunk_size_line_parser_assert.svh"

module chunk_size_line_parser #(
  parameter int SIZE_BITS = csp_pkg::SIZE_BITS_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [7:0]                   in_char_byte,
  input  logic                         in_has_byte,
  input  logic                         in_end_of_line,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [csp_pkg::OUT_BITS-1:0] out_chunk_size,
  output logic [2:0]                   out_status
);

  csp_pkg::item_t   in_item;
  csp_pkg::item_t   stage_item;
  logic             stage_valid;
  logic             stage_adv;
  logic             res_ready;
  logic             res_push;
  csp_pkg::result_t res;
  csp_pkg::result_t out_res;

  assign in_item.char_byte   = in_char_byte;
  assign in_item.has_byte    = in_has_byte;
  assign in_item.end_of_line = in_end_of_line;

  // input register
  csp_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .s_valid  (stage_valid),
    .s_item   (stage_item),
    .s_adv    (stage_adv)
  );

  // line state and result build
  csp_parser #(
    .SIZE_BITS (SIZE_BITS)
  ) u_parse (
    .clk       (clk),
    .rst_n     (rst_n),
    .s_valid   (stage_valid),
    .s_item    (stage_item),
    .s_adv     (stage_adv),
    .res_ready (res_ready),
    .res_push  (res_push),
    .res       (res)
  );

  // result register
  csp_out_stage u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .res_push  (res_push),
    .res       (res),
    .res_ready (res_ready),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_res   (out_res)
  );

  assign out_chunk_size = out_res.chunk_size;
  assign out_status     = out_res.status;

  // checks
  `CSP_ASSERT_IMP(a_size_zero_on_error, out_valid && (out_status != csp_pkg::ST_OK), out_chunk_size == '0, "chunk size not zero on error status")
  `CSP_ASSERT_IMP(a_stall_cause, !in_ready, stage_valid && stage_item.end_of_line && out_valid && !out_ready, "input stalled without a waiting result")
  `CSP_ASSERT_NXT(a_push_shows, res_push, out_valid, "pushed result not presented")

endmodule
